// ===== hdl/mev_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mev_pkg - shared types and constants for the mesh element volume block
// Beat formats, derived datapath widths, decomposition table and FSM states.
// ----------------------------------------------------------------------------
package mev_pkg;

    // Coordinate format
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int OUT_FRAC   = 24;
    localparam int SCALE_FRAC = 8;
    localparam int SCALE_W    = 16;
    localparam int VOL_W      = 64;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);

    // Vertex store geometry
    localparam int VERTEX_DEPTH = 8;
    localparam int VIDX_W       = 3;

    // Derived datapath widths
    localparam int DIFF_W  = COORD_BITS + 1;       // edge difference
    localparam int CROSS_W = 2 * DIFF_W + 1;       // cross product component
    localparam int TRIP_W  = CROSS_W + DIFF_W + 2; // one determinant
    localparam int SUM_W   = TRIP_W + 3;           // up to five determinants
    localparam int HALF_W  = (SUM_W + 1) / 2;      // magnitude split for scaling
    localparam int MA_W    = CROSS_W;
    localparam int MB_W    = (DIFF_W > SCALE_W + 1) ? DIFF_W : SCALE_W + 1;
    localparam int MP_W    = MA_W + MB_W;
    localparam int PROD_W  = SUM_W + SCALE_W;

    // volume = prod / (6 * 2^SHIFT) = (prod scaled by 2^-(SHIFT+1)) / 3
    localparam int SHIFT    = 3 * FRAC_BITS + SCALE_FRAC - OUT_FRAC;
    localparam int DSH      = SHIFT + 1;
    localparam int RSH      = (DSH >= 0) ? DSH : 0;
    localparam int LSH      = (DSH < 0) ? -DSH : 0;
    localparam int DIV_W    = PROD_W - DSH;
    localparam int DIV_CHUNK_W = 16;   // dividend digit handled per step
    localparam int DIV_STEPS   = (DIV_W + DIV_CHUNK_W - 1) / DIV_CHUNK_W;
    localparam int DIV_PAD_W   = DIV_STEPS * DIV_CHUNK_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int QX_W     = (DIV_W > VOL_W + 1) ? DIV_W : VOL_W + 1;

    localparam logic [VOL_W-1:0] VOL_MIN = {1'b1, {(VOL_W-1){1'b0}}};
    localparam logic [VOL_W-1:0] VOL_MAX = ~VOL_MIN;

    // Element type codes
    localparam logic [1:0] MODE_TET   = 2'd0;
    localparam logic [1:0] MODE_PRISM = 2'd1;
    localparam logic [1:0] MODE_HEX   = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // Decomposition terms: apex, then the three far vertices
    localparam int TERMS  = 9;
    localparam int TERM_W = 4;
    localparam logic [VIDX_W-1:0] DECOMP [TERMS][4] = '{
        '{3'd3, 3'd0, 3'd1, 3'd2},
        '{3'd2, 3'd3, 3'd5, 3'd4},
        '{3'd2, 3'd0, 3'd3, 3'd4},
        '{3'd2, 3'd1, 3'd0, 3'd4},
        '{3'd0, 3'd1, 3'd4, 3'd3},
        '{3'd2, 3'd1, 3'd3, 3'd6},
        '{3'd5, 3'd4, 3'd1, 3'd6},
        '{3'd7, 3'd4, 3'd6, 3'd3},
        '{3'd4, 3'd1, 3'd6, 3'd3}
    };

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vertex_t;

    typedef struct packed {
        diff_t x;
        diff_t y;
        diff_t z;
    } diff3_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [VIDX_W-1:0] vertex_index;
        coord_t            coord_x;
        coord_t            coord_y;
        coord_t            coord_z;
    } in_beat_t;

    typedef struct packed {
        logic signed [VOL_W-1:0] volume;
        logic                    saturated;
    } out_beat_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
    } div_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } state_t;

    function automatic logic [TERM_W-1:0] mode_first_term(input logic [1:0] mode);
        logic [TERM_W-1:0] t;
        unique case (mode)
            MODE_TET:   t = TERM_W'(0);
            MODE_PRISM: t = TERM_W'(1);
            MODE_HEX:   t = TERM_W'(4);
            default:    t = TERM_W'(0);
        endcase
        return t;
    endfunction

    function automatic logic [2:0] mode_term_count(input logic [1:0] mode);
        logic [2:0] n;
        unique case (mode)
            MODE_TET:   n = 3'd1;
            MODE_PRISM: n = 3'd3;
            MODE_HEX:   n = 3'd5;
            default:    n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [VIDX_W-1:0] mode_last_vertex(input logic [1:0] mode);
        logic [VIDX_W-1:0] v;
        unique case (mode)
            MODE_TET:   v = 3'd3;
            MODE_PRISM: v = 3'd5;
            MODE_HEX:   v = 3'd7;
            default:    v = 3'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/mev_vertex_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mev_vertex_store - eight-entry vertex memory
// One write port, one read port with registered read data. No reset.
// ----------------------------------------------------------------------------
module mev_vertex_store
    import mev_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [VIDX_W-1:0] wr_addr,
    input  vertex_t           wr_data,
    input  logic [VIDX_W-1:0] rd_addr,
    output vertex_t           rd_data
);

    vertex_t mem [VERTEX_DEPTH];
    vertex_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/mev_div3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mev_div3 - divide by three, one 16-bit digit per cycle
// Long division on DIV_CHUNK_W-bit digits, each digit quotient taken from a
// reciprocal multiply.
// ----------------------------------------------------------------------------
module mev_div3
    import mev_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  div_req_t         req,
    output logic [DIV_W-1:0] quotient,
    output logic             done
);

    localparam int CUR_W    = DIV_CHUNK_W + 2;
    localparam int RECIP_SH = DIV_CHUNK_W + 3;
    localparam logic [CUR_W-1:0] RECIP = CUR_W'(((1 << RECIP_SH) + 2) / 3);

    logic [DIV_PAD_W-1:0]   dq_reg, dq_next;
    logic [1:0]             rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [CUR_W-1:0]       cur;
    logic [2*CUR_W-1:0]     recip_prod;
    logic [DIV_CHUNK_W-1:0] qdigit;
    logic [CUR_W-1:0]       qdigit_x3;

    // dividend digits shift out the top while quotient digits shift in the
    // bottom; cur < 3 * 2^DIV_CHUNK_W keeps the reciprocal quotient exact
    always_comb begin
        cur        = {rem_reg, dq_reg[DIV_PAD_W-1 -: DIV_CHUNK_W]};
        recip_prod = cur * RECIP;
        qdigit     = DIV_CHUNK_W'(recip_prod >> RECIP_SH);
        qdigit_x3  = {1'b0, qdigit, 1'b0} + {2'b00, qdigit};
        rem_next   = 2'(cur - qdigit_x3);
        dq_next    = {dq_reg[DIV_PAD_W-DIV_CHUNK_W-1:0], qdigit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            dq_reg  <= DIV_PAD_W'(req.dividend);
            rem_reg <= '0;
        end else if (busy_reg) begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = dq_reg[DIV_W-1:0];
    assign done     = done_reg;

endmodule

// ===== hdl/mesh_element_volume.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_element_volume - signed volume of tetrahedra, prisms and hexahedra
// Collects element vertices and computes the scaled, saturated volume.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one vertex per beat (type, index, Q7.8 x/y/z). Vertices are
//   written into an 8-entry store. A beat with an unused type code is taken
//   and dropped. The beat carrying an element's last vertex (index 3, 5 or 7)
//   starts the volume computation; s_ready stays high after every other beat.
//   m_ channel: one result beat per element, volume with 24 fraction bits,
//   clipped to the signed 64-bit range, with a flag when clipping happened.
//   cfg_we/cfg_wdata: scale_cube register (Q8.8), write only while idle.
// Sequence:
//   per decomposition term, 5 load steps and 13 steps of the shared
//   multiplier; then the scaling steps, the divide-by-3 unit, a state that
//   takes its quotient and the load of the result register, up to m_valid.
//   s_ready is low meanwhile and returns high as the result is loaded.
// Reset: aresetn (sync, active low) clears the sequencer and the result
//   valid flag; scale_cube returns to 1.0. The vertex store is not cleared.
// Stall: the result register holds a beat until m_ready; vertices keep
//   loading meanwhile, and a finished volume waits until the register frees.
// ----------------------------------------------------------------------------
module mesh_element_volume
    import mev_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [SCALE_W-1:0] cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_beat_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_beat_t          m_data
);

    // load steps: issue apex read, then take apex, p, q, r data
    localparam logic [3:0] LD_ISSUE_A = 4'd0;
    localparam logic [3:0] LD_TAKE_A  = 4'd1;
    localparam logic [3:0] LD_TAKE_P  = 4'd2;
    localparam logic [3:0] LD_TAKE_Q  = 4'd3;
    localparam logic [3:0] LD_TAKE_R  = 4'd4;

    // multiply steps, named after the product issued (or the step's job)
    localparam logic [3:0] MS_VYWZ = 4'd0;
    localparam logic [3:0] MS_VZWY = 4'd1;
    localparam logic [3:0] MS_CX   = 4'd2;
    localparam logic [3:0] MS_UXC  = 4'd3;
    localparam logic [3:0] MS_VZWX = 4'd4;
    localparam logic [3:0] MS_VXWZ = 4'd5;
    localparam logic [3:0] MS_CY   = 4'd6;
    localparam logic [3:0] MS_UYC  = 4'd7;
    localparam logic [3:0] MS_VXWY = 4'd8;
    localparam logic [3:0] MS_VYWX = 4'd9;
    localparam logic [3:0] MS_CZ   = 4'd10;
    localparam logic [3:0] MS_UZC  = 4'd11;
    localparam logic [3:0] MS_LAST = 4'd12;

    // scaling steps
    localparam logic [3:0] SC_MAG = 4'd0;
    localparam logic [3:0] SC_LO  = 4'd1;
    localparam logic [3:0] SC_HI  = 4'd2;
    localparam logic [3:0] SC_SUM = 4'd3;
    localparam logic [3:0] SC_GO  = 4'd4;

    state_t            state_reg, state_next;
    logic [3:0]        step_reg, step_next;
    logic [TERM_W-1:0] term_reg, term_next;
    logic [2:0]        left_reg, left_next;

    logic [SCALE_W-1:0] scale_cube_reg;

    logic              in_take;
    logic              mode_ok;
    logic              elem_last;
    logic              elem_start;
    logic              out_load;
    logic [VIDX_W-1:0] rd_addr;
    vertex_t           rd_data;
    vertex_t           wr_vertex;

    vertex_t                  a_reg;
    diff3_t                   u_reg, v_reg, w_reg;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [MP_W-1:0]   prod_reg;
    logic signed [CROSS_W-1:0] cr_reg;
    logic signed [CROSS_W-1:0] cross_p;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_p;
    logic [SUM_W-1:0]         mag_reg;
    logic                     neg_reg;
    logic [PROD_W-1:0]        pacc_reg;
    logic [PROD_W-1:0]        prod_u;

    div_req_t          div_req;
    logic [DIV_W-1:0]  quotient;
    logic              div_done;
    logic [QX_W-1:0]   qx;
    logic [QX_W-1:0]   q_limit;
    out_beat_t         result;
    logic              m_valid_reg;
    out_beat_t         m_data_reg;

    function automatic diff3_t vdiff(input vertex_t a, input vertex_t b);
        diff3_t d;
        d.x = {a.x[COORD_BITS-1], a.x} - {b.x[COORD_BITS-1], b.x};
        d.y = {a.y[COORD_BITS-1], a.y} - {b.y[COORD_BITS-1], b.y};
        d.z = {a.z[COORD_BITS-1], a.z} - {b.z[COORD_BITS-1], b.z};
        return d;
    endfunction

    function automatic logic signed [MA_W-1:0] ext_a(input diff_t d);
        return MA_W'(d);
    endfunction

    function automatic logic signed [MB_W-1:0] ext_b(input diff_t d);
        return MB_W'(d);
    endfunction

    // ---------------- input decode ----------------
    assign mode_ok   = (s_data.mode != MODE_NONE);
    assign elem_last = mode_ok && (s_data.vertex_index == mode_last_vertex(s_data.mode));
    assign in_take   = s_valid && s_ready;

    assign wr_vertex.x = s_data.coord_x;
    assign wr_vertex.y = s_data.coord_y;
    assign wr_vertex.z = s_data.coord_z;

    mev_vertex_store u_store (
        .aclk    (aclk),
        .wr_en   (in_take && mode_ok),
        .wr_addr (s_data.vertex_index),
        .wr_data (wr_vertex),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_cube_reg <= SCALE_RESET;
        end else if (cfg_we) begin
            scale_cube_reg <= cfg_wdata;
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            term_reg  <= '0;
            left_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            term_reg  <= term_next;
            left_reg  <= left_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        step_next        = step_reg;
        term_next        = term_reg;
        left_next        = left_reg;
        s_ready          = 1'b0;
        elem_start       = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(pacc_reg >> RSH) << LSH;
        rd_addr          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && elem_last) begin
                    elem_start = 1'b1;
                    state_next = ST_LOAD;
                    step_next  = LD_ISSUE_A;
                    term_next  = mode_first_term(s_data.mode);
                    left_next  = 3'(mode_term_count(s_data.mode) - 3'd1);
                end
            end
            ST_LOAD: begin
                if (step_reg < LD_TAKE_R) begin
                    rd_addr = DECOMP[term_reg][step_reg[1:0]];
                end
                if (step_reg == LD_TAKE_R) begin
                    state_next = ST_MUL;
                    step_next  = MS_VYWZ;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_MUL: begin
                if (step_reg == MS_LAST) begin
                    if (left_reg == '0) begin
                        state_next = ST_SCALE;
                        step_next  = SC_MAG;
                    end else begin
                        state_next = ST_LOAD;
                        step_next  = LD_ISSUE_A;
                        term_next  = term_reg + 1'b1;
                        left_next  = left_reg - 1'b1;
                    end
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_SCALE: begin
                if (step_reg == SC_GO) begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- shared multiplier ----------------
    // operand select; the product is registered and consumed in the next step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_MUL) begin
            case (step_reg)
                MS_VYWZ: begin mul_a = ext_a(v_reg.y); mul_b = ext_b(w_reg.z); end
                MS_VZWY: begin mul_a = ext_a(v_reg.z); mul_b = ext_b(w_reg.y); end
                MS_UXC:  begin mul_a = cr_reg;         mul_b = ext_b(u_reg.x); end
                MS_VZWX: begin mul_a = ext_a(v_reg.z); mul_b = ext_b(w_reg.x); end
                MS_VXWZ: begin mul_a = ext_a(v_reg.x); mul_b = ext_b(w_reg.z); end
                MS_UYC:  begin mul_a = cr_reg;         mul_b = ext_b(u_reg.y); end
                MS_VXWY: begin mul_a = ext_a(v_reg.x); mul_b = ext_b(w_reg.y); end
                MS_VYWX: begin mul_a = ext_a(v_reg.y); mul_b = ext_b(w_reg.x); end
                MS_UZC:  begin mul_a = cr_reg;         mul_b = ext_b(u_reg.z); end
                default: ;
            endcase
        end else if (state_reg == ST_SCALE) begin
            case (step_reg)
                SC_LO: begin
                    mul_a = MA_W'(mag_reg[HALF_W-1:0]);
                    mul_b = MB_W'(scale_cube_reg);
                end
                SC_HI: begin
                    mul_a = MA_W'(mag_reg[SUM_W-1:HALF_W]);
                    mul_b = MB_W'(scale_cube_reg);
                end
                default: ;
            endcase
        end
    end

    assign cross_p = CROSS_W'(prod_reg);
    assign sum_p   = SUM_W'(prod_reg);
    assign prod_u  = PROD_W'(prod_reg);

    // ---------------- datapath ----------------
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;

        if (elem_start) begin
            sum_reg <= '0;
        end

        if (state_reg == ST_LOAD) begin
            case (step_reg)
                LD_TAKE_A: a_reg <= rd_data;
                LD_TAKE_P: u_reg <= vdiff(a_reg, rd_data);
                LD_TAKE_Q: v_reg <= vdiff(a_reg, rd_data);
                LD_TAKE_R: w_reg <= vdiff(a_reg, rd_data);
                default: ;
            endcase
        end

        // cx = vy*wz - vz*wy, cy = vz*wx - vx*wz, cz = vx*wy - vy*wx
        if (state_reg == ST_MUL) begin
            case (step_reg) inside
                MS_VZWY, MS_VXWZ, MS_VYWX: cr_reg  <= cross_p;
                MS_CX, MS_CY, MS_CZ:       cr_reg  <= cr_reg - cross_p;
                MS_VZWX, MS_VXWY, MS_LAST: sum_reg <= sum_reg + sum_p;
                default: ;
            endcase
        end

        if (state_reg == ST_SCALE) begin
            case (step_reg)
                SC_MAG: begin
                    neg_reg <= sum_reg[SUM_W-1];
                    mag_reg <= sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
                end
                SC_HI:  pacc_reg <= prod_u;
                SC_SUM: pacc_reg <= pacc_reg + (prod_u << HALF_W);
                default: ;
            endcase
        end
    end

    mev_div3 u_div3 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .quotient (quotient),
        .done     (div_done)
    );

    // ---------------- sign and clipping ----------------
    assign qx      = QX_W'(quotient);
    assign q_limit = QX_W'(1) << (VOL_W - 1);

    always_comb begin
        if (neg_reg) begin
            result.saturated = (qx > q_limit);
            result.volume    = result.saturated ? VOL_MIN : VOL_W'(0) - VOL_W'(qx);
        end else begin
            result.saturated = (qx >= q_limit);
            result.volume    = result.saturated ? VOL_MAX : VOL_W'(qx);
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hdl/mev_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mev_checker - port-level checks for mesh_element_volume
// Bound to the top level; watches the vertex and result channels.
// ----------------------------------------------------------------------------
module mev_checker
    import mev_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_beat_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    logic take_last;
    logic take_plain;

    assign take_last  = s_valid && s_ready && (s_data.mode != MODE_NONE)
                        && (s_data.vertex_index == mode_last_vertex(s_data.mode));
    assign take_plain = s_valid && s_ready && !take_last;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat present after reset");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    a_busy_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        take_last |=> !s_ready)
        else $error("ready while computing an element");

    a_ready_on_plain: assert property (@(posedge aclk) disable iff (!aresetn)
        take_plain |=> s_ready)
        else $error("ready dropped after a non-final vertex");

    a_sat_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |-> (m_data.volume == VOL_MIN || m_data.volume == VOL_MAX))
        else $error("saturated volume not at a range limit");

endmodule

bind mesh_element_volume mev_checker u_mev_checker (.*);
